>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/msr_pkg.sv
`default_nettype none
package msr_pkg;
    localparam int unsigned FIELD_W      = 32;
    localparam int unsigned OUT_DATA_W   = 64;
    localparam int unsigned SEARCH_LIMIT = 1024;
    localparam int unsigned SEARCH_W     = 11;
endpackage
`default_nettype wire

>>> sv/msr_mulmod.sv
`default_nettype none
`include "assert_macros.svh"
module msr_mulmod #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    input  wire logic [WIDTH-1:0] i_p,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_res
);
    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH+1:0] w_sum;
    logic [WIDTH+1:0] w_p1;
    logic [WIDTH+1:0] w_p2;
    logic [WIDTH+1:0] w_red;

    // One bit of the multiplier per cycle: acc = 2*acc + bit*x, reduced mod p.
    always_comb begin
        w_p1  = {2'b00, i_p};
        w_p2  = {1'b0, i_p, 1'b0};
        w_sum = {1'b0, r_acc, 1'b0} + (r_y[WIDTH-1] ? {2'b00, r_x} : '0);
        if (w_sum >= w_p2) begin
            w_red = w_sum - w_p2;
        end else if (w_sum >= w_p1) begin
            w_red = w_sum - w_p1;
        end else begin
            w_red = w_sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(WIDTH);
            n_acc  = '0;
            n_x    = i_x;
            n_y    = i_y;
        end else if (r_busy) begin
            n_acc = w_red[WIDTH-1:0];
            n_y   = {r_y[WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy && !r_done)
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
endmodule
`default_nettype wire

>>> sv/modular_square_root.sv
`default_nettype none
`include "assert_macros.svh"
// Channel   Direction  Fields
// s_axis    in         tdata[31:0] n_value
// m_axis    out        tuser[0] found; tdata[31:0] root_low, [63:32] root_high
// cfg       in         data[31:0] modulus
//
// One word at a time; s_axis_tready is high only while the sequencer is idle.
// Each modular multiply runs through issue, start, WIDTH shift-add steps and done.
// An exponentiation takes up to 2*WIDTH multiplies, the Cipolla ladder up to
// 10*WIDTH, and each non-residue candidate one multiply plus one exponentiation.
// Reset is synchronous and sets the modulus to 3; m_axis stalls hold the result.
module modular_square_root
    import msr_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [FIELD_W-1:0]    s_axis_tdata,   // n_value
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // root_low, root_high
    output logic                       m_axis_tuser,   // found
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [FIELD_W-1:0]    i_cfg_data      // modulus
);
    localparam int unsigned BW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_WAIT   = 5'd1;
    localparam logic [4:0] S_RED    = 5'd2;
    localparam logic [4:0] S_POW_SQ = 5'd3;
    localparam logic [4:0] S_POW_SD = 5'd4;
    localparam logic [4:0] S_POW_MD = 5'd5;
    localparam logic [4:0] S_POW_END = 5'd6;
    localparam logic [4:0] S_SRCH   = 5'd7;
    localparam logic [4:0] S_SRCH_T = 5'd8;
    localparam logic [4:0] S_E1     = 5'd9;
    localparam logic [4:0] S_E2     = 5'd10;
    localparam logic [4:0] S_E3     = 5'd11;
    localparam logic [4:0] S_E4     = 5'd12;
    localparam logic [4:0] S_E5     = 5'd13;
    localparam logic [4:0] S_E6     = 5'd14;
    localparam logic [4:0] S_FIN    = 5'd15;

    localparam logic [1:0] M_EULER = 2'd0;
    localparam logic [1:0] M_ROOT  = 2'd1;
    localparam logic [1:0] M_SRCH  = 2'd2;

    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] p);
        logic [WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[WIDTH-1:0];
    endfunction

    logic [FIELD_W-1:0]    r_mod;
    logic [4:0]            r_state, n_state;
    logic [4:0]            r_ret, n_ret;
    logic                  r_mstart, n_mstart;
    logic [WIDTH-1:0]      r_mx, n_mx, r_my, n_my;
    logic [WIDTH-1:0]      r_p, n_p, r_pn, n_pn, r_n, n_n;
    logic [WIDTH-1:0]      r_e, n_e, r_base, n_base, r_r, n_r;
    logic [BW-1:0]         r_bit, n_bit;
    logic [1:0]            r_mode, n_mode;
    logic [SEARCH_W-1:0]   r_i, n_i;
    logic [WIDTH-1:0]      r_a, n_a, r_w, n_w;
    logic [WIDTH-1:0]      r_x0, n_x0, r_x1, n_x1, r_t1, n_t1, r_c0, n_c0;
    logic                  r_emul, n_emul;
    logic                  r_ok, n_ok;
    logic                  r_ovalid, n_ovalid;
    logic                  r_found, n_found;
    logic [FIELD_W-1:0]    r_lo, n_lo, r_hi, n_hi;

    logic                  w_mdone;
    logic [WIDTH-1:0]      w_mres;
    logic [WIDTH+FIELD_W-1:0]  w_cfg_ext, w_in_ext, w_lo_ext, w_hi_ext;
    logic [WIDTH+SEARCH_W-1:0] w_i_ext, w_p_ext;
    logic [WIDTH-1:0]      w_half, w_y0, w_y1, w_lo, w_hi;
    logic                  w_ebit, w_in_acc;

    msr_mulmod #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_p     (r_p),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_ext     = {{WIDTH{1'b0}}, r_mod};
    assign w_in_ext      = {{WIDTH{1'b0}}, s_axis_tdata};
    assign w_i_ext       = {{WIDTH{1'b0}}, r_i};
    assign w_p_ext       = {{SEARCH_W{1'b0}}, r_p};
    assign w_half        = (r_p - 1'b1) >> 1;
    assign w_ebit        = r_e[r_bit];
    assign w_y0          = r_emul ? r_a : r_x0;
    assign w_y1          = r_emul ? WIDTH'(1) : r_x1;
    assign w_lo          = ((r_p - r_r) < r_r) ? (r_p - r_r) : r_r;
    assign w_hi          = ((r_p - r_r) < r_r) ? r_r : (r_p - r_r);
    assign w_lo_ext      = {{FIELD_W{1'b0}}, w_lo};
    assign w_hi_ext      = {{FIELD_W{1'b0}}, w_hi};

    always_comb begin
        n_state = r_state;  n_ret = r_ret;    n_mstart = 1'b0;
        n_mx = r_mx;        n_my = r_my;      n_p = r_p;      n_pn = r_pn;
        n_n = r_n;          n_e = r_e;        n_base = r_base; n_r = r_r;
        n_bit = r_bit;      n_mode = r_mode;  n_i = r_i;      n_a = r_a;
        n_w = r_w;          n_x0 = r_x0;      n_x1 = r_x1;    n_t1 = r_t1;
        n_c0 = r_c0;        n_emul = r_emul;  n_ok = r_ok;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_found = r_found;  n_lo = r_lo;      n_hi = r_hi;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_p = w_cfg_ext[WIDTH-1:0];
                    if (w_cfg_ext[WIDTH-1:0] < WIDTH'(3)) begin
                        n_ok = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        // Horner reduction of the input through the multiplier.
                        n_mx = WIDTH'(1);
                        n_my = w_in_ext[WIDTH-1:0];
                        n_mstart = 1'b1;
                        n_ret = S_RED;
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (w_mdone) begin
                    n_state = r_ret;
                end
            end
            S_RED: begin
                n_n = w_mres;
                n_pn = r_p - w_mres;
                if (w_mres <= WIDTH'(1)) begin
                    n_r = w_mres;
                    n_ok = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_r = WIDTH'(1);
                    n_base = w_mres;
                    n_e = w_half;
                    n_bit = BW'(WIDTH - 1);
                    n_mode = M_EULER;
                    n_state = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                n_mx = r_r;
                n_my = r_r;
                n_mstart = 1'b1;
                n_ret = S_POW_SD;
                n_state = S_WAIT;
            end
            S_POW_SD, S_POW_MD: begin
                n_r = w_mres;
                if (r_state == S_POW_SD && w_ebit) begin
                    n_mx = w_mres;
                    n_my = r_base;
                    n_mstart = 1'b1;
                    n_ret = S_POW_MD;
                    n_state = S_WAIT;
                end else if (r_bit == '0) begin
                    n_state = S_POW_END;
                end else begin
                    n_bit = r_bit - 1'b1;
                    n_state = S_POW_SQ;
                end
            end
            S_POW_END: begin
                case (r_mode)
                    M_EULER: begin
                        if (r_r != WIDTH'(1)) begin
                            n_ok = 1'b0;
                            n_state = S_FIN;
                        end else if (r_p[1:0] == 2'b11) begin
                            n_r = WIDTH'(1);
                            n_base = r_n;
                            n_e = (r_p >> 2) + 1'b1;
                            n_bit = BW'(WIDTH - 1);
                            n_mode = M_ROOT;
                            n_state = S_POW_SQ;
                        end else begin
                            n_i = SEARCH_W'(1);
                            n_state = S_SRCH;
                        end
                    end
                    M_ROOT: begin
                        n_ok = 1'b1;
                        n_state = S_FIN;
                    end
                    M_SRCH: begin
                        if (r_r == r_p - 1'b1) begin
                            n_a = w_i_ext[WIDTH-1:0];
                            n_x0 = WIDTH'(1);
                            n_x1 = '0;
                            n_e = (r_p >> 1) + WIDTH'(r_p[0]);
                            n_bit = BW'(WIDTH - 1);
                            n_emul = 1'b0;
                            n_state = S_E1;
                        end else begin
                            n_i = r_i + 1'b1;
                            n_state = S_SRCH;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SRCH: begin
                if (r_i >= SEARCH_W'(SEARCH_LIMIT) || w_i_ext >= w_p_ext) begin
                    n_ok = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_mx = w_i_ext[WIDTH-1:0];
                    n_my = w_i_ext[WIDTH-1:0];
                    n_mstart = 1'b1;
                    n_ret = S_SRCH_T;
                    n_state = S_WAIT;
                end
            end
            S_SRCH_T: begin
                n_w = add_mod(w_mres, r_pn, r_p);
                n_base = add_mod(w_mres, r_pn, r_p);
                n_r = WIDTH'(1);
                n_e = w_half;
                n_bit = BW'(WIDTH - 1);
                n_mode = M_SRCH;
                n_state = S_POW_SQ;
            end
            S_E1: begin
                n_mx = r_x0;
                n_my = w_y0;
                n_mstart = 1'b1;
                n_ret = S_E2;
                n_state = S_WAIT;
            end
            S_E2: begin
                n_t1 = w_mres;
                n_mx = r_x1;
                n_my = w_y1;
                n_mstart = 1'b1;
                n_ret = S_E3;
                n_state = S_WAIT;
            end
            S_E3: begin
                n_mx = w_mres;
                n_my = r_w;
                n_mstart = 1'b1;
                n_ret = S_E4;
                n_state = S_WAIT;
            end
            S_E4: begin
                n_c0 = add_mod(r_t1, w_mres, r_p);
                n_mx = r_x0;
                n_my = w_y1;
                n_mstart = 1'b1;
                n_ret = S_E5;
                n_state = S_WAIT;
            end
            S_E5: begin
                n_t1 = w_mres;
                n_mx = r_x1;
                n_my = w_y0;
                n_mstart = 1'b1;
                n_ret = S_E6;
                n_state = S_WAIT;
            end
            S_E6: begin
                n_x0 = r_c0;
                n_x1 = add_mod(r_t1, w_mres, r_p);
                if (!r_emul && w_ebit) begin
                    n_emul = 1'b1;
                    n_state = S_E1;
                end else begin
                    n_emul = 1'b0;
                    if (r_bit == '0) begin
                        n_r = r_c0;
                        n_ok = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_bit = r_bit - 1'b1;
                        n_state = S_E1;
                    end
                end
            end
            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_found = r_ok;
                    if (!r_ok || r_r == '0) begin
                        n_lo = '0;
                        n_hi = '0;
                    end else begin
                        n_lo = w_lo_ext[FIELD_W-1:0];
                        n_hi = w_hi_ext[FIELD_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod    <= FIELD_W'(3);
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mod <= i_cfg_data;
            end
            r_state  <= n_state;
            r_mstart <= n_mstart;
            r_ovalid <= n_ovalid;
        end
        r_ret <= n_ret;   r_mx <= n_mx;     r_my <= n_my;     r_p <= n_p;
        r_pn <= n_pn;     r_n <= n_n;       r_e <= n_e;       r_base <= n_base;
        r_r <= n_r;       r_bit <= n_bit;   r_mode <= n_mode; r_i <= n_i;
        r_a <= n_a;       r_w <= n_w;       r_x0 <= n_x0;     r_x1 <= n_x1;
        r_t1 <= n_t1;     r_c0 <= n_c0;     r_emul <= n_emul; r_ok <= n_ok;
        r_found <= n_found; r_lo <= n_lo;   r_hi <= n_hi;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_hi, r_lo};
    assign m_axis_tuser  = r_found;

    `ASSERT_IMPL(a_start_wait, i_clk, i_rst_n, r_mstart, r_state == S_WAIT)
    `ASSERT_IMPL(a_nf_zero, i_clk, i_rst_n, r_ovalid && !r_found, r_lo == '0 && r_hi == '0)
    `ASSERT_IMPL(a_order, i_clk, i_rst_n, r_ovalid, r_lo <= r_hi)
    `ASSERT_IMPL(a_done_wait, i_clk, i_rst_n, w_mdone, r_state == S_WAIT)
endmodule
`default_nettype wire
